[rtl/core/linked_list_pool_manager_unit_defines.svh]
// Assertion macros shared by the pool manager RTL.
`ifndef LINKED_LIST_POOL_MANAGER_UNIT_DEFINES_SVH
`define LINKED_LIST_POOL_MANAGER_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define LLPM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define LLPM_ASSERT_NEXT(lbl, cond, nxt, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) \
	else $error(msg);

`endif

[rtl/core/llpm_pkg.sv]
// Field widths, operation codes and shared types of the pool manager.
`timescale 1ns / 1ps
`default_nettype none

package llpm_pkg;

	// Fixed field widths of the request and response channels
	localparam int MODE_W  = 3;
	localparam int INDEX_W = 8;
	localparam int DATA_W  = 32;
	localparam int LEN_W   = 8;

	typedef logic [MODE_W-1:0] mode_t;

	// Operation codes carried in the mode field
	localparam mode_t MODE_PUSH   = 3'd0;
	localparam mode_t MODE_POP    = 3'd1;
	localparam mode_t MODE_FREE   = 3'd2;
	localparam mode_t MODE_CHAIN  = 3'd3;
	localparam mode_t MODE_LENGTH = 3'd4;
	localparam mode_t MODE_READ   = 3'd5;
	localparam mode_t MODE_PURGE  = 3'd6;

	// Write enables of the record store
	typedef struct packed {
		logic link_we;
		logic value_we;
	} wr_ctl_t;

endpackage

`default_nettype wire

[rtl/core/llpm_if.sv]
// Request and response channel interfaces of the pool manager.
`timescale 1ns / 1ps
`default_nettype none

interface llpm_req_if;
	logic                                valid;
	logic                                ready;
	logic [llpm_pkg::MODE_W-1:0]         mode;
	logic [llpm_pkg::INDEX_W-1:0]        elem_index;
	logic signed [llpm_pkg::DATA_W-1:0]  value_in;

	modport source (output valid, output mode, output elem_index, output value_in,
		input ready);
	modport sink (input valid, input mode, input elem_index, input value_in,
		output ready);
endinterface

interface llpm_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [llpm_pkg::INDEX_W-1:0]        result_index;
	logic signed [llpm_pkg::DATA_W-1:0]  value_out;
	logic [llpm_pkg::LEN_W-1:0]          list_length;
	logic                                status;

	modport source (output valid, output result_index, output value_out,
		output list_length, output status, input ready);
	modport sink (input valid, input result_index, input value_out,
		input list_length, input status, output ready);
endinterface

`default_nettype wire

[rtl/core/llpm_store.sv]
// Record store: link and value memories with one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module llpm_store #(
	parameter int DEPTH   = 256,
	parameter int IDX_W   = $clog2(DEPTH),
	parameter int VALUE_W = 32
) (
	input  logic                 clk,
	input  llpm_pkg::wr_ctl_t    wr,
	input  logic [IDX_W-1:0]     wr_addr,
	input  logic [IDX_W-1:0]     link_wdata,
	input  logic [VALUE_W-1:0]   value_wdata,
	input  logic [IDX_W-1:0]     rd_addr,
	output logic [IDX_W-1:0]     link_rd_q,
	output logic [VALUE_W-1:0]   value_rd_q
);

	logic [IDX_W-1:0]   link_mem  [DEPTH];
	logic [VALUE_W-1:0] value_mem [DEPTH];

	// Link memory: write, then registered read of the old contents
	always_ff @(posedge clk) begin
		if (wr.link_we) begin
			link_mem[wr_addr] <= link_wdata;
		end
		link_rd_q <= link_mem[rd_addr];
	end

	// Value memory: same addressing as the link memory
	always_ff @(posedge clk) begin
		if (wr.value_we) begin
			value_mem[wr_addr] <= value_wdata;
		end
		value_rd_q <= value_mem[rd_addr];
	end

endmodule

`default_nettype wire

[rtl/core/linked_list_pool_manager_unit.sv]
// Linked-list pool manager: sequencer, free chain head and result register.
//
// Usage: one request channel (mode, elem_index, value_in) and one response
// channel (result_index, value_out, list_length, status), both valid/ready.
// Each request produces exactly one response, in request order.
// After reset the unit primes the link memory, one entry a cycle, and holds
// ready low meanwhile; entry i then links i+1 and the last entry links 0.
// Push, pop and read wait on the registered read of the record memory;
// free, the unused code, a null index and a push on an empty pool go
// straight to the final step. Length and free chain walk the chain, and
// purge visits records until a match or the tail (a middle entry is first
// bridged over, then released); walks stop after POOL_DEPTH records. Below
// a pool depth of 256, an index at or above the depth is reduced by
// repeated subtraction of the depth to bring it in range.
// Throughput: one request at a time; ready returns in the same cycle that
// the response becomes valid.
// The response sits in an output register: the next request is taken while
// a response waits, and the unit only holds in its final step when a second
// response is ready and the receiver still stalls.
`timescale 1ns / 1ps
`default_nettype none

`include "linked_list_pool_manager_unit_defines.svh"

module linked_list_pool_manager_unit #(
	parameter int POOL_DEPTH  = 256,
	parameter int VALUE_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	llpm_req_if.sink   req,
	llpm_rsp_if.source rsp
);

	localparam int IDX_W = $clog2(POOL_DEPTH);
	localparam int CNT_W = IDX_W + 1;
	localparam int RED_W = (IDX_W > llpm_pkg::INDEX_W) ? IDX_W : llpm_pkg::INDEX_W;
	localparam int EXT_W = (VALUE_WIDTH > llpm_pkg::DATA_W) ? VALUE_WIDTH : llpm_pkg::DATA_W;
	localparam int SAT_W = (CNT_W > 9) ? CNT_W : 9;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(POOL_DEPTH);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_REDUCE,
		S_START,
		S_PUSH,
		S_ACCESS,
		S_WALK,
		S_PURGE,
		S_UNLINK,
		S_FIN
	} state_t;

	state_t                       state_q, state_d;
	logic [IDX_W-1:0]             clr_q, clr_d;
	llpm_pkg::mode_t              mode_q, mode_d;
	logic [RED_W-1:0]             idx_q, idx_d;
	logic [VALUE_WIDTH-1:0]       val_q, val_d;
	logic [IDX_W-1:0]             fh_q, fh_d;
	logic [IDX_W-1:0]             cur_q, cur_d;
	logic [IDX_W-1:0]             prev_q, prev_d;
	logic [CNT_W-1:0]             steps_q, steps_d;
	logic [IDX_W-1:0]             res_q, res_d;
	logic [llpm_pkg::DATA_W-1:0]  vout_q, vout_d;
	logic [llpm_pkg::LEN_W-1:0]   len_q, len_d;
	logic                         st_q, st_d;
	logic                         out_valid_q, out_valid_d;
	logic [llpm_pkg::INDEX_W-1:0] out_res_q, out_res_d;
	logic [llpm_pkg::DATA_W-1:0]  out_vout_q, out_vout_d;
	logic [llpm_pkg::LEN_W-1:0]   out_len_q, out_len_d;
	logic                         out_st_q, out_st_d;

	llpm_pkg::wr_ctl_t            wr;
	logic [IDX_W-1:0]             wr_addr;
	logic [IDX_W-1:0]             link_wdata;
	logic [VALUE_WIDTH-1:0]       value_wdata;
	logic [IDX_W-1:0]             rd_addr;
	logic [IDX_W-1:0]             link_rd;
	logic [VALUE_WIDTH-1:0]       value_rd;

	logic [IDX_W-1:0]             elem;
	logic [CNT_W-1:0]             steps_nx;
	logic signed [EXT_W-1:0]      vin_ext;
	logic signed [VALUE_WIDTH-1:0] rd_val_s;
	logic signed [EXT_W-1:0]      rd_val_ext;

	llpm_store #(
		.DEPTH   (POOL_DEPTH),
		.IDX_W   (IDX_W),
		.VALUE_W (VALUE_WIDTH)
	) u_store (
		.clk         (clk),
		.wr          (wr),
		.wr_addr     (wr_addr),
		.link_wdata  (link_wdata),
		.value_wdata (value_wdata),
		.rd_addr     (rd_addr),
		.link_rd_q   (link_rd),
		.value_rd_q  (value_rd)
	);

	// Narrow the stored value to its width and widen the read value by sign
	assign vin_ext    = EXT_W'(req.value_in);
	assign rd_val_s   = value_rd;
	assign rd_val_ext = EXT_W'(rd_val_s);

	assign elem     = idx_q[IDX_W-1:0];
	assign steps_nx = steps_q + CNT_W'(1);

	// Channel outputs
	assign req.ready        = (state_q == S_IDLE);
	assign rsp.valid        = out_valid_q;
	assign rsp.result_index = out_res_q;
	assign rsp.value_out    = out_vout_q;
	assign rsp.list_length  = out_len_q;
	assign rsp.status       = out_st_q;

	// Sequencer: at most one memory write per step, walks advance one record a cycle
	always_comb begin
		state_d     = state_q;
		clr_d       = clr_q;
		mode_d      = mode_q;
		idx_d       = idx_q;
		val_d       = val_q;
		fh_d        = fh_q;
		cur_d       = cur_q;
		prev_d      = prev_q;
		steps_d     = steps_q;
		res_d       = res_q;
		vout_d      = vout_q;
		len_d       = len_q;
		st_d        = st_q;
		out_valid_d = out_valid_q && !rsp.ready;
		out_res_d   = out_res_q;
		out_vout_d  = out_vout_q;
		out_len_d   = out_len_q;
		out_st_d    = out_st_q;
		wr          = '0;
		wr_addr     = cur_q;
		link_wdata  = fh_q;
		value_wdata = val_q;
		rd_addr     = cur_q;

		unique case (state_q)
			S_CLEAR: begin
				// Prime the free chain in index order
				wr.link_we = 1'b1;
				wr_addr    = clr_q;
				link_wdata = (clr_q == LAST_IDX) ? '0 : clr_q + IDX_W'(1);
				clr_d      = clr_q + IDX_W'(1);
				if (clr_q == LAST_IDX) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req.valid) begin
					mode_d  = req.mode;
					idx_d   = RED_W'(req.elem_index);
					val_d   = vin_ext[VALUE_WIDTH-1:0];
					state_d = S_REDUCE;
				end
			end
			S_REDUCE: begin
				// Bring the index into the pool by repeated subtraction
				if ({1'b0, idx_q} >= (RED_W + 1)'(POOL_DEPTH)) begin
					idx_d = idx_q - RED_W'(POOL_DEPTH);
				end else begin
					state_d = S_START;
				end
			end
			S_START: begin
				res_d   = '0;
				vout_d  = '0;
				len_d   = '0;
				st_d    = 1'b0;
				cur_d   = elem;
				prev_d  = '0;
				steps_d = CNT_W'(1);
				rd_addr = elem;
				state_d = S_FIN;
				case (mode_q)
					llpm_pkg::MODE_PUSH: begin
						if (fh_q == '0) begin
							st_d = 1'b1;
						end else begin
							rd_addr = fh_q;
							cur_d   = fh_q;
							state_d = S_PUSH;
						end
					end
					llpm_pkg::MODE_POP, llpm_pkg::MODE_READ: begin
						if (elem != '0) begin
							state_d = S_ACCESS;
						end
					end
					llpm_pkg::MODE_FREE: begin
						if (elem != '0) begin
							wr.link_we = 1'b1;
							wr_addr    = elem;
							link_wdata = fh_q;
							fh_d       = elem;
						end
					end
					llpm_pkg::MODE_CHAIN, llpm_pkg::MODE_LENGTH: begin
						if (elem != '0) begin
							state_d = S_WALK;
						end
					end
					llpm_pkg::MODE_PURGE: begin
						res_d   = elem;
						steps_d = '0;
						if (elem != '0) begin
							state_d = S_PURGE;
						end
					end
					default: begin
					end
				endcase
			end
			S_PUSH: begin
				// Unhook the free head and fill it
				fh_d           = link_rd;
				wr.link_we     = 1'b1;
				wr.value_we    = 1'b1;
				wr_addr        = cur_q;
				link_wdata     = elem;
				value_wdata    = val_q;
				res_d          = cur_q;
				state_d        = S_FIN;
			end
			S_ACCESS: begin
				res_d  = link_rd;
				vout_d = rd_val_ext[llpm_pkg::DATA_W-1:0];
				if (mode_q == llpm_pkg::MODE_POP) begin
					wr.link_we = 1'b1;
					wr_addr    = cur_q;
					link_wdata = fh_q;
					fh_d       = cur_q;
				end
				state_d = S_FIN;
			end
			S_WALK: begin
				// Advance to the tail, bounded by the pool depth
				if (link_rd != '0 && steps_q < DEPTH_C) begin
					cur_d   = link_rd;
					rd_addr = link_rd;
					steps_d = steps_nx;
				end else begin
					if (mode_q == llpm_pkg::MODE_CHAIN) begin
						wr.link_we = 1'b1;
						wr_addr    = cur_q;
						link_wdata = fh_q;
						fh_d       = elem;
					end else begin
						len_d = (SAT_W'(steps_q) > SAT_W'(255)) ? 8'd255 : 8'(steps_q);
					end
					state_d = S_FIN;
				end
			end
			S_PURGE: begin
				if (value_rd == val_q) begin
					if (prev_q == '0) begin
						// Match at the head: release it and report the new head
						res_d      = link_rd;
						wr.link_we = 1'b1;
						wr_addr    = cur_q;
						link_wdata = fh_q;
						fh_d       = cur_q;
						state_d    = S_FIN;
					end else begin
						// Bridge the predecessor over the match first
						wr.link_we = 1'b1;
						wr_addr    = prev_q;
						link_wdata = link_rd;
						state_d    = S_UNLINK;
					end
				end else begin
					prev_d  = cur_q;
					cur_d   = link_rd;
					rd_addr = link_rd;
					steps_d = steps_nx;
					if (link_rd == '0 || steps_nx >= DEPTH_C) begin
						state_d = S_FIN;
					end
				end
			end
			S_UNLINK: begin
				wr.link_we = 1'b1;
				wr_addr    = cur_q;
				link_wdata = fh_q;
				fh_d       = cur_q;
				state_d    = S_FIN;
			end
			S_FIN: begin
				// Load the response register once it is free
				if (!out_valid_q || rsp.ready) begin
					out_valid_d = 1'b1;
					out_res_d   = llpm_pkg::INDEX_W'(res_q);
					out_vout_d  = vout_q;
					out_len_d   = len_q;
					out_st_d    = st_q;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State, priming counter, free head and response valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			fh_q        <= IDX_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			clr_q       <= clr_d;
			fh_q        <= fh_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Working and payload registers
	always_ff @(posedge clk) begin
		mode_q     <= mode_d;
		idx_q      <= idx_d;
		val_q      <= val_d;
		cur_q      <= cur_d;
		prev_q     <= prev_d;
		steps_q    <= steps_d;
		res_q      <= res_d;
		vout_q     <= vout_d;
		len_q      <= len_d;
		st_q       <= st_d;
		out_res_q  <= out_res_d;
		out_vout_q <= out_vout_d;
		out_len_q  <= out_len_d;
		out_st_q   <= out_st_d;
	end

	`LLPM_ASSERT(a_walk_bound, state_q == S_WALK |-> steps_q <= DEPTH_C, "walk ran past pool depth")
	`LLPM_ASSERT(a_idle_no_write, state_q == S_IDLE |-> !wr.link_we && !wr.value_we, "write while idle")
	`LLPM_ASSERT(a_value_on_push, wr.value_we |-> state_q == S_PUSH, "value write outside push")
	`LLPM_ASSERT(a_status_push, state_q == S_FIN && st_q |-> mode_q == llpm_pkg::MODE_PUSH, "status set without push")
	`LLPM_ASSERT_NEXT(a_clear_done, state_q == S_CLEAR && clr_q == LAST_IDX, state_q == S_IDLE, "priming pass did not end")

endmodule

`default_nettype wire

[test/tb_linked_list_pool_manager_unit.sv]
// Self-checking testbench of the pool manager: directed and random requests against a predictor.
`timescale 1ns / 1ps

module tb_linked_list_pool_manager_unit;

	localparam int              DEPTH            = 256;
	localparam llpm_pkg::mode_t MODE_NONE        = 3'd7;
	localparam logic            STATUS_OK        = 1'b0;
	localparam logic            STATUS_EXHAUSTED = 1'b1;
	localparam int              LIST_COUNT       = 4;
	localparam int              EPISODES         = 8;
	localparam int              EPISODE_REQUESTS = 135;
	localparam int              FILL_CAP         = 300;
	localparam int              LONG_HOLD        = 150;
	localparam int              DRAIN_CYCLES     = 300;
	localparam int              REPORT_LIMIT     = 10;
	localparam longint          TIMEOUT_NS       = 25_000_000;

	typedef logic [llpm_pkg::INDEX_W-1:0]       index_t;
	typedef logic signed [llpm_pkg::DATA_W-1:0] value_t;
	typedef logic [llpm_pkg::LEN_W-1:0]         len_t;

	typedef struct packed {
		index_t result_index;
		value_t value_out;
		len_t   list_length;
		logic   status;
	} pool_result_t;

	// Mirror of the record pool plus the queue of responses still owed
	class pool_scoreboard;
		index_t       link_mem [DEPTH];
		value_t       value_mem [DEPTH];
		bit           written [DEPTH];
		index_t       free_head;
		pool_result_t due_responses [$];
		int           errors;
		int           checked;
		int           mode_count [8];
		int           exhausted_count;
		int           max_walk;

		function new();
			for (int i = 0; i < DEPTH; i++) begin
				link_mem[i]  = index_t'((i + 1) % DEPTH);
				value_mem[i] = '0;
				written[i]   = 1'b0;
			end
			free_head = index_t'(1);
		endfunction

		function void report(input string msg);
			errors++;
			if (errors <= REPORT_LIMIT)
				$display("%0t: %s", $time, msg);
		endfunction

		// Follow links to the tail; a walk stops after a pool's worth of records
		function index_t chain_tail(input index_t start, output int steps);
			index_t cur;
			cur = start;
			steps = 1;
			while (link_mem[cur] != 0 && steps < DEPTH) begin
				cur = link_mem[cur];
				steps++;
			end
			return cur;
		endfunction

		function void give_back(input index_t e);
			link_mem[e] = free_head;
			free_head = e;
		endfunction

		// Apply one accepted request to the mirror and queue its response
		function pool_result_t note_request(input llpm_pkg::mode_t mode, input index_t e,
				input value_t v);
			pool_result_t r;
			index_t       cur;
			index_t       prev;
			int           steps;
			bit           found;
			r = '0;
			mode_count[mode]++;
			case (mode)
				llpm_pkg::MODE_PUSH: begin
					if (free_head == 0) begin
						r.status = STATUS_EXHAUSTED;
						exhausted_count++;
					end else begin
						cur = free_head;
						free_head = link_mem[cur];
						link_mem[cur] = e;
						value_mem[cur] = v;
						written[cur] = 1'b1;
						r.result_index = cur;
					end
				end
				llpm_pkg::MODE_POP, llpm_pkg::MODE_READ: begin
					if (e != 0) begin
						r.value_out = value_mem[e];
						r.result_index = link_mem[e];
						if (mode == llpm_pkg::MODE_POP)
							give_back(e);
					end
				end
				llpm_pkg::MODE_FREE: if (e != 0) give_back(e);
				llpm_pkg::MODE_CHAIN, llpm_pkg::MODE_LENGTH: begin
					if (e != 0) begin
						cur = chain_tail(e, steps);
						if (steps > max_walk)
							max_walk = steps;
						if (mode == llpm_pkg::MODE_CHAIN) begin
							link_mem[cur] = free_head;
							free_head = e;
						end else begin
							r.list_length = (steps > 255) ? len_t'(255) : len_t'(steps);
						end
					end
				end
				llpm_pkg::MODE_PURGE: begin
					r.result_index = e;
					prev = '0;
					cur = e;
					steps = 0;
					found = 1'b0;
					// unlink the first record holding the value
					while (cur != 0 && steps < DEPTH && !found) begin
						if (value_mem[cur] == v) begin
							if (prev == 0)
								r.result_index = link_mem[cur];
							else
								link_mem[prev] = link_mem[cur];
							give_back(cur);
							found = 1'b1;
						end else begin
							prev = cur;
							cur = link_mem[cur];
							steps++;
						end
					end
				end
				default: ;
			endcase
			due_responses.push_back(r);
			return r;
		endfunction

		// Compare one accepted response with the oldest one owed
		function void check_response(input pool_result_t got);
			pool_result_t want;
			checked++;
			if (due_responses.size() == 0) begin
				report($sformatf("response %0d arrived with none owed", checked));
				return;
			end
			want = due_responses.pop_front();
			if (got.result_index !== want.result_index)
				report($sformatf("response %0d result_index: expected %0d, got %0d",
					checked, want.result_index, got.result_index));
			if (got.value_out !== want.value_out)
				report($sformatf("response %0d value_out: expected %h, got %h",
					checked, want.value_out, got.value_out));
			if (got.list_length !== want.list_length)
				report($sformatf("response %0d list_length: expected %0d, got %0d",
					checked, want.list_length, got.list_length));
			if (got.status !== want.status)
				report($sformatf("response %0d status: expected %b, got %b",
					checked, want.status, got.status));
		endfunction
	endclass

	logic clk;
	logic arst_n;

	llpm_req_if req ();
	llpm_rsp_if rsp ();

	linked_list_pool_manager_unit #(
		.POOL_DEPTH (DEPTH),
		.VALUE_WIDTH(llpm_pkg::DATA_W)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	pool_scoreboard sb;
	index_t         heads [LIST_COUNT];
	bit             send_calm;
	bit             recv_calm;
	int             rsp_count;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one request, hold it until accepted, then predict its response
	task automatic issue(input llpm_pkg::mode_t mode, input index_t e, input value_t v,
			output pool_result_t r);
		int gap;
		gap = send_calm ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid      <= 1'b1;
		req.mode       <= mode;
		req.elem_index <= e;
		req.value_in   <= v;
		@(posedge clk);
		while (req.ready !== 1'b1) @(posedge clk);
		r = sb.note_request(mode, e, v);
	endtask

	// Hold the request side until every owed response is in
	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (sb.due_responses.size() != 0) @(posedge clk);
	endtask

	// Favor a few repeating values so that purges find matches
	function automatic value_t any_value();
		case ($urandom_range(0, 7))
			0: return value_t'(0);
			1: return value_t'(-1);
			2: return value_t'(32'h8000_0000);
			3: return value_t'(32'h7FFF_FFFF);
			4: return value_t'(7);
			default: return value_t'($urandom);
		endcase
	endfunction

	function automatic index_t pick_member(input index_t head);
		index_t cur;
		int     hops;
		cur = head;
		hops = $urandom_range(0, 7);
		repeat (hops)
			if (sb.link_mem[cur] != 0)
				cur = sb.link_mem[cur];
		return cur;
	endfunction

	// A purge may only visit records that were written by a push
	function automatic bit purge_safe(input index_t head, input value_t v);
		index_t cur;
		int     steps;
		cur = head;
		steps = 0;
		while (cur != 0 && steps < DEPTH) begin
			if (!sb.written[cur])
				return 1'b0;
			if (sb.value_mem[cur] == v)
				return 1'b1;
			cur = sb.link_mem[cur];
			steps++;
		end
		return 1'b1;
	endfunction

	task automatic run_directed();
		pool_result_t r;
		index_t       a;
		index_t       b;
		index_t       c;
		index_t       d;
		index_t       s;
		// unused code and every operation on the null index
		issue(MODE_NONE, 8'hFF, value_t'(-1), r);
		issue(llpm_pkg::MODE_LENGTH, '0, '0, r);
		issue(llpm_pkg::MODE_READ, '0, '0, r);
		issue(llpm_pkg::MODE_POP, '0, '0, r);
		issue(llpm_pkg::MODE_FREE, '0, '0, r);
		issue(llpm_pkg::MODE_CHAIN, '0, '0, r);
		issue(llpm_pkg::MODE_PURGE, '0, value_t'(5), r);
		// build c -> b -> a with extreme values, then d in front
		issue(llpm_pkg::MODE_PUSH, '0, value_t'(32'h7FFF_FFFF), r);
		a = r.result_index;
		issue(llpm_pkg::MODE_PUSH, a, value_t'(32'h8000_0000), r);
		b = r.result_index;
		issue(llpm_pkg::MODE_PUSH, b, value_t'(-1), r);
		c = r.result_index;
		issue(llpm_pkg::MODE_PUSH, c, value_t'(0), r);
		d = r.result_index;
		issue(llpm_pkg::MODE_LENGTH, d, '0, r);
		issue(llpm_pkg::MODE_READ, b, '0, r);
		// purge at the head, at the tail, and with no match
		issue(llpm_pkg::MODE_PURGE, d, value_t'(0), r);
		issue(llpm_pkg::MODE_PURGE, c, value_t'(32'h7FFF_FFFF), r);
		issue(llpm_pkg::MODE_PURGE, c, value_t'(12345), r);
		issue(llpm_pkg::MODE_POP, c, '0, r);
		issue(llpm_pkg::MODE_FREE, b, '0, r);
		// self-linked record: walks are cut off after a full pool
		s = sb.free_head;
		issue(llpm_pkg::MODE_PUSH, s, value_t'(32'h5A5A_5A5A), r);
		issue(llpm_pkg::MODE_LENGTH, s, '0, r);
		issue(llpm_pkg::MODE_PURGE, s, value_t'(0), r);
		issue(llpm_pkg::MODE_CHAIN, s, '0, r);
	endtask

	// Push onto list 0 until the pool runs dry (at most FILL_CAP tries), then return the whole chain
	task automatic fill_pool();
		pool_result_t r;
		int           tries;
		r = '0;
		tries = 0;
		while (r.status != STATUS_EXHAUSTED && tries < FILL_CAP) begin
			issue(llpm_pkg::MODE_PUSH, heads[0], any_value(), r);
			if (r.status == STATUS_OK)
				heads[0] = r.result_index;
			tries++;
		end
		issue(llpm_pkg::MODE_PUSH, heads[0], any_value(), r);
		issue(llpm_pkg::MODE_LENGTH, heads[0], value_t'($urandom), r);
		issue(llpm_pkg::MODE_CHAIN, heads[0], value_t'($urandom), r);
		heads[0] = '0;
	endtask

	// Mostly well-formed list traffic, with a little noise on arbitrary indexes
	task automatic random_request();
		pool_result_t r;
		int           k;
		int           pick;
		index_t       e;
		index_t       m;
		index_t       nxt;
		value_t       v;
		k = $urandom_range(0, LIST_COUNT - 1);
		pick = $urandom_range(0, 99);
		e = heads[k];
		if (pick < 35 || (e == 0 && pick < 85)) begin
			issue(llpm_pkg::MODE_PUSH, e, any_value(), r);
			if (r.status == STATUS_OK)
				heads[k] = r.result_index;
		end else if (pick < 47) begin
			if (sb.written[e]) begin
				issue(llpm_pkg::MODE_POP, e, value_t'($urandom), r);
				heads[k] = r.result_index;
			end else begin
				issue(llpm_pkg::MODE_LENGTH, e, value_t'($urandom), r);
			end
		end else if (pick < 55) begin
			m = pick_member(e);
			issue(sb.written[m] ? llpm_pkg::MODE_READ : llpm_pkg::MODE_LENGTH, m,
				value_t'($urandom), r);
		end else if (pick < 65) begin
			issue(llpm_pkg::MODE_LENGTH, e, value_t'($urandom), r);
		end else if (pick < 77) begin
			m = pick_member(e);
			v = ($urandom_range(0, 9) < 6 && sb.written[m]) ? sb.value_mem[m] : any_value();
			if (purge_safe(e, v)) begin
				issue(llpm_pkg::MODE_PURGE, e, v, r);
				heads[k] = r.result_index;
			end else begin
				issue(llpm_pkg::MODE_LENGTH, e, v, r);
			end
		end else if (pick < 81) begin
			nxt = sb.link_mem[e];
			issue(llpm_pkg::MODE_FREE, e, value_t'($urandom), r);
			heads[k] = nxt;
		end else if (pick < 85) begin
			issue(llpm_pkg::MODE_CHAIN, e, value_t'($urandom), r);
			heads[k] = '0;
		end else if (pick < 93) begin
			// harmless noise
			m = index_t'($urandom_range(0, DEPTH - 1));
			case ($urandom_range(0, 2))
				0: issue(llpm_pkg::MODE_LENGTH, m, value_t'($urandom), r);
				1: issue(sb.written[m] ? llpm_pkg::MODE_READ : llpm_pkg::MODE_LENGTH, m,
					value_t'($urandom), r);
				default: issue(MODE_NONE, m, value_t'($urandom), r);
			endcase
		end else begin
			// noise that may break lists and the free chain
			m = index_t'($urandom_range(0, DEPTH - 1));
			v = any_value();
			case ($urandom_range(0, 3))
				0: issue(llpm_pkg::MODE_PUSH, m, v, r);
				1: issue(llpm_pkg::MODE_FREE, m, v, r);
				2: issue(llpm_pkg::MODE_CHAIN, m, v, r);
				default: begin
					if (sb.written[m])
						issue(llpm_pkg::MODE_POP, m, v, r);
					else if (purge_safe(m, v))
						issue(llpm_pkg::MODE_PURGE, m, v, r);
					else
						issue(llpm_pkg::MODE_LENGTH, m, v, r);
				end
			endcase
		end
	endtask

	// Drive requests, then wait for the last responses and decide the run
	initial begin : request_source
		req.valid      <= 1'b0;
		req.mode       <= MODE_NONE;
		req.elem_index <= '0;
		req.value_in   <= '0;
		arst_n         <= 1'b0;
		sb = new();
		send_calm = 1'b0;
		for (int k = 0; k < LIST_COUNT; k++)
			heads[k] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		run_directed();
		for (int ep = 0; ep < EPISODES; ep++) begin
			send_calm = (ep == 1) || ($urandom_range(0, 3) == 0);
			if (ep == 2 || ep == 5)
				fill_pool();
			repeat (EPISODE_REQUESTS) random_request();
			if (ep == 3 || ep == 6)
				drain();
		end
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.due_responses.size() != 0)
			sb.report($sformatf("%0d responses never arrived", sb.due_responses.size()));
		$display("Requests: push %0d, pop %0d, free %0d, chain free %0d, length %0d,",
			sb.mode_count[llpm_pkg::MODE_PUSH], sb.mode_count[llpm_pkg::MODE_POP],
			sb.mode_count[llpm_pkg::MODE_FREE], sb.mode_count[llpm_pkg::MODE_CHAIN],
			sb.mode_count[llpm_pkg::MODE_LENGTH]);
		$display("  read %0d, purge %0d, idle code %0d; pool ran dry on %0d pushes,",
			sb.mode_count[llpm_pkg::MODE_READ], sb.mode_count[llpm_pkg::MODE_PURGE],
			sb.mode_count[MODE_NONE], sb.exhausted_count);
		$display("  longest walk %0d records, %0d responses checked, %0d failures",
			sb.max_walk, sb.checked, sb.errors);
		if (sb.errors == 0)
			$display("tb_linked_list_pool_manager_unit: PASS");
		else
			$display("tb_linked_list_pool_manager_unit: FAIL");
		$finish;
	end

	// Accept responses with random stalls and two long hold-offs
	initial begin : response_sink
		int           stall;
		pool_result_t got;
		rsp.ready <= 1'b0;
		recv_calm = 1'b0;
		rsp_count = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rsp_count == 300 || rsp_count == 1200)
				stall = LONG_HOLD;
			else
				stall = recv_calm ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
			while (rsp.valid !== 1'b1) @(posedge clk);
			got.result_index = rsp.result_index;
			got.value_out    = rsp.value_out;
			got.list_length  = rsp.list_length;
			got.status       = rsp.status;
			sb.check_response(got);
			rsp_count++;
			if (rsp_count % 150 == 0)
				recv_calm = (rsp_count == 450) || ($urandom_range(0, 3) == 0);
		end
	end

	// End a hung run
	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("Timed out after %0d responses", rsp_count);
		$display("tb_linked_list_pool_manager_unit: FAIL");
		$finish;
	end

endmodule
